// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// assertion macros shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- src/iee_pkg.sv -----
// ----------------------------------------------------------------------------
// iee_pkg
// shared constants and types of the expression evaluator
// ----------------------------------------------------------------------------
package iee_pkg;
	localparam int STACK_DEPTH = 16;
	localparam int VALUE_WIDTH = 48;
	localparam int FRAC_BITS = 16;

	typedef enum logic [2:0] {
		OP_OPEN = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2, OP_MUL = 3'd3, OP_DIV = 3'd4
	} op_t;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_PAREN = 3'd1;
	localparam logic [2:0] ST_DIVZ = 3'd2;
	localparam logic [2:0] ST_OVFL = 3'd3;
	localparam logic [2:0] ST_OPND = 3'd4;

	localparam logic [7:0] CH_EQ = 8'h3d;
	localparam logic [7:0] CH_OPEN = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_ADD = 8'h2b;
	localparam logic [7:0] CH_SUB = 8'h2d;
	localparam logic [7:0] CH_MUL = 8'h2a;
	localparam logic [7:0] CH_DIV = 8'h2f;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// request to the arithmetic unit
	typedef struct packed {
		logic start;
		op_t  op;
	} alu_req_t;

	function automatic logic [1:0] prec(op_t op);
		logic [1:0] p;
		p = 2'd2;
		if (op == OP_MUL || op == OP_DIV) p = 2'd3;
		else if (op == OP_OPEN) p = 2'd1;
		return p;
	endfunction
endpackage

// ----- src/iee_ram.sv -----
// ----------------------------------------------------------------------------
// iee_ram
// generic ram with one write port and one read port, registered read
// ----------------------------------------------------------------------------
module iee_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ----- src/iee_alu.sv -----
// ----------------------------------------------------------------------------
// iee_alu
// shared saturating fixed point unit: add, sub, shift-add multiply, divide
// ----------------------------------------------------------------------------
module iee_alu #(
	parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH,
	parameter int FRAC_BITS = iee_pkg::FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  iee_pkg::alu_req_t      req,
	input  logic [VALUE_WIDTH-1:0] a,
	input  logic [VALUE_WIDTH-1:0] b,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] res
);
	localparam int W = VALUE_WIDTH;
	localparam int PW = 2 * W + FRAC_BITS + 1;
	localparam int NB = W + FRAC_BITS;
	localparam int CW = $clog2(NB + 1);
	localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	typedef enum logic [1:0] {IDLE, MUL, DIV, FIN} st_t;
	st_t st_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic [W-1:0]  y_q;
	logic [PW-1:0] acc_q;    // product, or remainder for division
	logic [NB-1:0] num_q;    // multiplier, or shifted dividend then quotient for division

	logic [W-1:0] ma, mb;
	logic [W:0] sum, dif;
	logic [W:0] rem_sh, rem_sub;
	logic [W-1:0] lim;
	logic done_d;

	always_comb begin
		ma = a[W-1] ? (~a + 1'b1) : a;
		mb = b[W-1] ? (~b + 1'b1) : b;
		sum = {a[W-1], a} + {b[W-1], b};
		dif = {a[W-1], a} - {b[W-1], b};
		rem_sh = {acc_q[W-1:0], num_q[NB-1]};
		rem_sub = rem_sh - {1'b0, y_q};
		lim = neg_q ? VMIN : VMAX;
		// add and sub finish without stepping, the others after the final step
		done_d = (st_q == FIN) || (st_q == IDLE && req.start
			&& (req.op == iee_pkg::OP_ADD || req.op == iee_pkg::OP_SUB));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			done <= 1'b0;
		end else begin
			done <= done_d;
			unique case (st_q)
				IDLE: if (req.start) begin
					neg_q <= a[W-1] ^ b[W-1];
					y_q <= mb;
					cnt_q <= '0;
					unique case (req.op)
						iee_pkg::OP_ADD, iee_pkg::OP_SUB: begin
							logic [W:0] s;
							s = (req.op == iee_pkg::OP_ADD) ? sum : dif;
							res <= (s[W] != s[W-1]) ? (s[W] ? VMIN : VMAX) : s[W-1:0];
						end
						iee_pkg::OP_MUL: begin
							acc_q <= '0;
							num_q <= NB'(ma);
							st_q <= MUL;
						end
						default: begin
							acc_q <= '0;
							num_q <= {ma, {FRAC_BITS{1'b0}}};
							st_q <= DIV;
						end
					endcase
				end
				MUL: begin
					// msb first shift-add, count ends at W
					acc_q <= (acc_q << 1) + (num_q[W-1] ? PW'(y_q) : '0);
					num_q <= num_q << 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(W - 1)) begin
						st_q <= FIN;
					end
				end
				DIV: begin
					if (!rem_sub[W]) begin
						acc_q <= PW'(rem_sub);
						num_q <= {num_q[NB-2:0], 1'b1};
					end else begin
						acc_q <= PW'(rem_sh);
						num_q <= {num_q[NB-2:0], 1'b0};
					end
					// count ends at zero so the final step tells it from a product
					if (cnt_q == CW'(NB - 1)) begin
						cnt_q <= '0;
						st_q <= FIN;
					end else cnt_q <= cnt_q + 1'b1;
				end
				FIN: begin
					logic [PW-1:0] m;
					if (cnt_q == CW'(W)) m = acc_q >> FRAC_BITS;
					else m = PW'(num_q);
					if (|m[PW-1:W-1] && !(neg_q && m == PW'(VMIN)))
						res <= lim;
					else
						res <= neg_q ? (~m[W-1:0] + 1'b1) : m[W-1:0];
					st_q <= IDLE;
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	`include "assert_macros.svh"
	`ASSERT_CLK(a_done_one, clk, arst_n, done |=> !done)
	`ASSERT_CLK(a_fin_done, clk, arst_n, (st_q == FIN) |=> done)
	`ASSERT_CLK(a_start_idle, clk, arst_n, req.start |-> (st_q == IDLE))
endmodule

// ----- src/infix_expression_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// infix_expression_evaluator_top
// character driven infix evaluator with operator and value stacks
// ----------------------------------------------------------------------------
// usage
//   input channel: one character per item on char_code, valid/ready
//   output channel: value and status, valid/ready, one item per '='
//   ready is high only when idle; an item holds the block from its
//   accepting cycle until ready returns, so items go one at a time
//   a digit is folded into the accumulator, other characters are dropped
//   a non-digit ends a number and pushes it; '(' goes on the operator stack
//   an operator first pops entries of equal or higher precedence, then is pushed
//   ')' pops operators down to its '(' and discards it, paren error if none
//   each popped operator reads two values, runs the alu and writes the result;
//   a zero divisor or missing operands set the status instead
//   '=' pops all operators, discarding each unmatched '(', then raises out_valid
//   ready stays low while an item is being worked on or a result waits
//   stalling the receiver holds the result and blocks further items
//   reset clears counts, accumulator, error code and the sequencer
//   stack memories are not cleared; entries are read only below counts
//   status: 0 ok, 1 paren, 2 divide by zero, 3 overflow, 4 missing operand
//   value is zero when status is not ok
//   overflow saturates, quotients truncate toward zero
// ----------------------------------------------------------------------------
module infix_expression_evaluator_top #(
	parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH,
	parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH,
	parameter int FRAC_BITS = iee_pkg::FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    char_code,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [VALUE_WIDTH-1:0] value,
	output logic [2:0]                    status
);
	localparam int W = VALUE_WIDTH;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};

	typedef enum logic [3:0] {
		S_IDLE, S_DIGIT, S_ENDNUM, S_DISPATCH, S_POP_RD, S_POP_WAIT, S_POP_CHK,
		S_VAL_RD, S_VAL_WAIT, S_ALU, S_PUSHOP, S_FINAL, S_FIN_WAIT, S_OUT
	} st_t;

	st_t st_q;
	logic [7:0]    ch_q;
	logic [CW-1:0] opc_q, valc_q;
	logic [W-1:0]  acc_q;
	logic          innum_q;
	logic [2:0]    err_q;
	iee_pkg::op_t  cur_q, top_q;
	logic [W-1:0]  b_q;
	logic          bread_q;
	logic [W+4:0]  mul10_s1;

	// stack ram ports
	logic op_we, val_we;
	logic [AW-1:0] op_wa, op_ra, val_wa, val_ra;
	logic [2:0] op_wd, op_rd;
	logic [W-1:0] val_wd, val_rd;

	iee_pkg::alu_req_t alu_req;
	logic alu_done;
	logic [W-1:0] alu_res;

	iee_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_opstk (
		.clk(clk), .we(op_we), .waddr(op_wa), .wdata(op_wd),
		.raddr(op_ra), .rdata(op_rd)
	);
	iee_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_valstk (
		.clk(clk), .we(val_we), .waddr(val_wa), .wdata(val_wd),
		.raddr(val_ra), .rdata(val_rd)
	);
	iee_alu #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_alu (
		.clk(clk), .arst_n(arst_n), .req(alu_req), .a(val_rd), .b(b_q),
		.done(alu_done), .res(alu_res)
	);

	logic is_op, is_digit;
	iee_pkg::op_t ch_op;
	logic [W-1:0] dd;
	always_comb begin
		is_digit = ch_q >= iee_pkg::CH_ZERO && ch_q <= iee_pkg::CH_NINE;
		is_op = 1'b1;
		ch_op = iee_pkg::OP_ADD;
		unique case (ch_q)
			iee_pkg::CH_ADD: ch_op = iee_pkg::OP_ADD;
			iee_pkg::CH_SUB: ch_op = iee_pkg::OP_SUB;
			iee_pkg::CH_MUL: ch_op = iee_pkg::OP_MUL;
			iee_pkg::CH_DIV: ch_op = iee_pkg::OP_DIV;
			default: is_op = 1'b0;
		endcase
		dd = W'(ch_q - iee_pkg::CH_ZERO) << FRAC_BITS;
		if (FRAC_BITS + 4 > W - 1 && (ch_q - iee_pkg::CH_ZERO) > 8'd0
			&& (64'(ch_q - iee_pkg::CH_ZERO) << FRAC_BITS) > 64'(VMAX)) dd = VMAX;
	end

	// ram control
	always_comb begin
		op_we = 1'b0; op_wa = opc_q[AW-1:0]; op_wd = cur_q;
		op_ra = opc_q[AW-1:0] - 1'b1;
		val_we = 1'b0; val_wa = valc_q[AW-1:0]; val_wd = acc_q;
		val_ra = valc_q[AW-1:0] - 1'b1;
		alu_req.start = 1'b0; alu_req.op = top_q;
		if (st_q == S_VAL_RD && bread_q) val_ra = valc_q[AW-1:0] - 2'd2;
		if (st_q == S_FINAL) val_ra = '0;
		if (st_q == S_ENDNUM && innum_q && valc_q < CW'(STACK_DEPTH)) val_we = 1'b1;
		if (st_q == S_PUSHOP && opc_q < CW'(STACK_DEPTH)) op_we = 1'b1;
		if (st_q == S_ALU && alu_done) begin
			val_we = 1'b1;
			val_wa = valc_q[AW-1:0] - 2'd2;
			val_wd = (top_q == iee_pkg::OP_DIV && b_q == '0) ? '0 : alu_res;
		end
		if (st_q == S_VAL_WAIT && bread_q && !(top_q == iee_pkg::OP_DIV && b_q == '0))
			alu_req.start = 1'b1;
	end

	assign in_ready = st_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			opc_q <= '0;
			valc_q <= '0;
			acc_q <= '0;
			innum_q <= 1'b0;
			err_q <= iee_pkg::ST_OK;
			out_valid <= 1'b0;
			bread_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: if (in_valid) begin
					ch_q <= char_code;
					st_q <= S_DIGIT;
				end
				S_DIGIT: begin
					// ten times accumulator through shifts, registered
					mul10_s1 <= ({5'd0, innum_q ? acc_q : '0} << 3)
						+ ({5'd0, innum_q ? acc_q : '0} << 1);
					if (is_digit) st_q <= S_ENDNUM;
					else if (is_op || ch_q == iee_pkg::CH_OPEN || ch_q == iee_pkg::CH_CLOSE
						|| ch_q == iee_pkg::CH_EQ) st_q <= S_ENDNUM;
					else st_q <= S_IDLE;
				end
				S_ENDNUM: begin
					if (is_digit) begin
						logic [W+5:0] t;
						t = {1'b0, mul10_s1} + (W+6)'(dd);
						acc_q <= (dd == VMAX || t > (W+6)'(VMAX)) ? VMAX : t[W-1:0];
						innum_q <= 1'b1;
						st_q <= S_IDLE;
					end else begin
						if (innum_q) begin
							if (valc_q < CW'(STACK_DEPTH)) valc_q <= valc_q + 1'b1;
							else if (err_q == iee_pkg::ST_OK) err_q <= iee_pkg::ST_OVFL;
						end
						innum_q <= 1'b0;
						acc_q <= '0;
						cur_q <= ch_op;
						st_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					if (ch_q == iee_pkg::CH_OPEN) begin
						cur_q <= iee_pkg::OP_OPEN;
						st_q <= S_PUSHOP;
					end else st_q <= S_POP_RD;
				end
				S_POP_RD: begin
					if (opc_q == '0) begin
						if (ch_q == iee_pkg::CH_CLOSE && err_q == iee_pkg::ST_OK)
							err_q <= iee_pkg::ST_PAREN;
						st_q <= (ch_q == iee_pkg::CH_EQ) ? S_FINAL
							: (is_op ? S_PUSHOP : S_IDLE);
					end else st_q <= S_POP_WAIT;
				end
				S_POP_WAIT: st_q <= S_POP_CHK;
				S_POP_CHK: begin
					top_q <= iee_pkg::op_t'(op_rd);
					if (is_op && (op_rd == iee_pkg::OP_OPEN
						|| iee_pkg::prec(iee_pkg::op_t'(op_rd)) < iee_pkg::prec(cur_q)))
						st_q <= S_PUSHOP;
					else begin
						opc_q <= opc_q - 1'b1;
						if (op_rd == iee_pkg::OP_OPEN) begin
							if (ch_q == iee_pkg::CH_EQ) begin
								if (err_q == iee_pkg::ST_OK) err_q <= iee_pkg::ST_PAREN;
								st_q <= S_POP_RD;
							end else st_q <= S_IDLE;
						end else if (valc_q < CW'(2)) begin
							if (err_q == iee_pkg::ST_OK) err_q <= iee_pkg::ST_OPND;
							st_q <= S_POP_RD;
						end else begin
							bread_q <= 1'b0;
							st_q <= S_VAL_RD;
						end
					end
				end
				S_VAL_RD: st_q <= S_VAL_WAIT;
				S_VAL_WAIT: begin
					if (!bread_q) begin
						b_q <= val_rd;
						bread_q <= 1'b1;
						st_q <= S_VAL_RD;
					end else if (top_q == iee_pkg::OP_DIV && b_q == '0) begin
						if (err_q == iee_pkg::ST_OK) err_q <= iee_pkg::ST_DIVZ;
						valc_q <= valc_q - 1'b1;
						st_q <= S_POP_RD;
					end else st_q <= S_ALU;
				end
				S_ALU: if (alu_done) begin
					valc_q <= valc_q - 1'b1;
					st_q <= S_POP_RD;
				end
				S_PUSHOP: begin
					if (opc_q < CW'(STACK_DEPTH)) opc_q <= opc_q + 1'b1;
					else if (err_q == iee_pkg::ST_OK) err_q <= iee_pkg::ST_OVFL;
					st_q <= S_IDLE;
				end
				S_FINAL: begin
					if (err_q == iee_pkg::ST_OK && valc_q != CW'(1)) err_q <= iee_pkg::ST_OPND;
					st_q <= S_FIN_WAIT;
				end
				S_FIN_WAIT: begin
					value <= (err_q == iee_pkg::ST_OK) ? val_rd : '0;
					status <= err_q;
					out_valid <= 1'b1;
					opc_q <= '0;
					valc_q <= '0;
					err_q <= iee_pkg::ST_OK;
					st_q <= S_OUT;
				end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`include "assert_macros.svh"
	`ASSERT_CLK(a_opc_range, clk, arst_n, opc_q <= CW'(STACK_DEPTH))
	`ASSERT_CLK(a_valc_range, clk, arst_n, valc_q <= CW'(STACK_DEPTH))
	`ASSERT_CLK(a_busy, clk, arst_n, out_valid |-> !in_ready)
	`ASSERT_CLK(a_out_clear, clk, arst_n, (out_valid && out_ready) |=> (err_q == iee_pkg::ST_OK))
endmodule
